>>> rtl/core/hrce_pkg.sv
// ----------------------------------------------------------------------------
// hrce_pkg
// Shared codes, widths and control structs of the range count estimator.
// ----------------------------------------------------------------------------
package hrce_pkg;

  localparam int CNT_W = 13;

  typedef logic [2:0] req_t;
  localparam req_t REQ_LOAD_X = 3'd0;
  localparam req_t REQ_LOAD_Y = 3'd1;
  localparam req_t REQ_ADD    = 3'd2;
  localparam req_t REQ_BUILD  = 3'd3;
  localparam req_t REQ_CLEAR  = 3'd4;
  localparam req_t REQ_QUERY  = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_INDEX = 2'd1;
  localparam status_t ST_PHASE = 2'd2;
  localparam status_t ST_CFG   = 2'd3;

  localparam logic CFG_COUNT_X = 1'b0;
  localparam logic CFG_COUNT_Y = 1'b1;

  typedef struct packed {
    logic    ld_x;
    logic    ld_y;
    logic    clr_start;
    logic    clr_wr;
    logic    srch_start;
    logic    srch_upd;
    logic    mul;
    logic    add_rd;
    logic    add_wr;
    logic    qa;
    logic    qb;
    logic    bld_start;
    logic    bld_rd;
    logic    bld_wr;
    logic    set_built;
    logic    clr_built;
    logic    res_load;
    logic    res_add;
    logic    res_query;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic built;
    logic idx_bad;
    logic srch_done;
    logic sweep_last;
    logic bld_last;
  } stat_t;

endpackage

>>> rtl/core/hrce_ctrl.sv
// ----------------------------------------------------------------------------
// hrce_ctrl
// Request sequencer: decodes requests and steps search, query, add, build
// and clear sweeps in the datapath.
// ----------------------------------------------------------------------------
module hrce_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  hrce_pkg::req_t  req_type,
  input  hrce_pkg::stat_t stat,
  output hrce_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [14:0] {
    S_INIT    = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_CLR     = 15'b000000000000100,
    S_SRCH_RD = 15'b000000000001000,
    S_SRCH_UP = 15'b000000000010000,
    S_MUL     = 15'b000000000100000,
    S_ADD_RD  = 15'b000000001000000,
    S_ADD_WR  = 15'b000000010000000,
    S_QA      = 15'b000000100000000,
    S_QB      = 15'b000001000000000,
    S_QC      = 15'b000010000000000,
    S_BLD_RD  = 15'b000100000000000,
    S_BLD_WR  = 15'b001000000000000,
    S_SPARE0  = 15'b010000000000000,
    S_SPARE1  = 15'b100000000000000
  } state_t;

  state_t         state, state_next;
  hrce_pkg::req_t req_q;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (req_type) inside
            hrce_pkg::REQ_LOAD_X, hrce_pkg::REQ_LOAD_Y: begin
              cmd.res_load = 1'b1;
              if (stat.idx_bad) cmd.res_status = hrce_pkg::ST_INDEX;
              else if (req_type == hrce_pkg::REQ_LOAD_X) cmd.ld_x = 1'b1;
              else cmd.ld_y = 1'b1;
            end
            hrce_pkg::REQ_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next = S_CLR;
            end
            hrce_pkg::REQ_ADD, hrce_pkg::REQ_BUILD, hrce_pkg::REQ_QUERY: begin
              if (!stat.cfg_ok) begin
                cmd.res_load = 1'b1;
                cmd.res_status = hrce_pkg::ST_CFG;
              end else if ((req_type == hrce_pkg::REQ_QUERY) != stat.built) begin
                cmd.res_load = 1'b1;
                cmd.res_status = hrce_pkg::ST_PHASE;
              end else if (req_type == hrce_pkg::REQ_BUILD) begin
                cmd.bld_start = 1'b1;
                state_next = S_BLD_RD;
              end else begin
                cmd.srch_start = 1'b1;
                state_next = S_SRCH_RD;
              end
            end
            default: cmd.res_load = 1'b1;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.sweep_last) begin
          cmd.clr_built = 1'b1;
          cmd.res_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SRCH_RD: state_next = stat.srch_done ? S_MUL : S_SRCH_UP;
      S_SRCH_UP: begin
        cmd.srch_upd = 1'b1;
        state_next = S_SRCH_RD;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = (req_q == hrce_pkg::REQ_ADD) ? S_ADD_RD : S_QA;
      end
      S_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_add = 1'b1;
        state_next = S_IDLE;
      end
      S_QA: begin
        cmd.qa = 1'b1;
        state_next = S_QB;
      end
      S_QB: begin
        cmd.qb = 1'b1;
        state_next = S_QC;
      end
      S_QC: begin
        cmd.res_load = 1'b1;
        cmd.res_query = 1'b1;
        state_next = S_IDLE;
      end
      S_BLD_RD: begin
        cmd.bld_rd = 1'b1;
        state_next = S_BLD_WR;
      end
      S_BLD_WR: begin
        cmd.bld_wr = 1'b1;
        if (stat.bld_last) begin
          cmd.set_built = 1'b1;
          cmd.res_load = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_BLD_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= cmd.res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) req_q <= req_type;
  end

endmodule

>>> rtl/core/hrce_dp.sv
// ----------------------------------------------------------------------------
// hrce_dp
// Datapath: boundary memories with four search lanes, cell memory with
// sweep, add and prefix query addressing, and result registers.
// ----------------------------------------------------------------------------
module hrce_dp #(
  parameter int BOUND_DEPTH = 4096,
  parameter int CELL_DEPTH  = 65536,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hrce_pkg::cmd_t                    cmd,
  output hrce_pkg::stat_t                   stat,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [hrce_pkg::CNT_W-1:0]        cfg_data,
  input  logic [11:0]                       entry_index,
  input  logic signed [KEY_WIDTH-1:0]       key_x_lo,
  input  logic signed [KEY_WIDTH-1:0]       key_x_hi,
  input  logic signed [KEY_WIDTH-1:0]       key_y_lo,
  input  logic signed [KEY_WIDTH-1:0]       key_y_hi,
  output hrce_pkg::status_t                 status,
  output logic [31:0]                       estimate,
  output logic [11:0]                       bucket_x,
  output logic [11:0]                       bucket_y
);

  localparam int IW = $clog2(BOUND_DEPTH);
  localparam int CW = $clog2(CELL_DEPTH);
  localparam int NW = hrce_pkg::CNT_W;
  localparam int PW = IW + NW;

  logic [NW-1:0] nx, ny;
  logic          cfg_ok, built;
  logic [2*NW-1:0] cfg_prod;

  logic signed [KEY_WIDTH-1:0] bx_mem [BOUND_DEPTH];
  logic signed [KEY_WIDTH-1:0] by_mem [BOUND_DEPTH];
  logic [COUNT_WIDTH-1:0]      cell_mem [CELL_DEPTH];

  logic [IW-1:0]               lo [4];
  logic [IW-1:0]               hi [4];
  logic [IW-1:0]               mid [4];
  logic signed [KEY_WIDTH-1:0] key [4];
  logic signed [KEY_WIDTH-1:0] brd [4];

  logic [CW-1:0] row_lo, row_hi, addr, raddr0, raddr1, waddr, nyc;
  logic [CW-1:0] byl_c, byh_c;
  logic [PW-1:0] prod_lo, prod_hi;
  logic [COUNT_WIDTH-1:0] rd0, rd1, pa, pb, wdata, rs_new, rowsum, est;
  logic          we;
  logic [NW-1:0] bi, bj;

  // configuration
  assign cfg_prod = (2*NW)'(nx) * (2*NW)'(ny);
  always_ff @(posedge clk) begin
    if (rst) begin
      nx <= NW'(1);
      ny <= NW'(1);
    end else begin
      if (cfg_we && cfg_index == hrce_pkg::CFG_COUNT_X) nx <= cfg_data;
      if (cfg_we && cfg_index == hrce_pkg::CFG_COUNT_Y) ny <= cfg_data;
    end
  end

  assign cfg_ok = (nx != '0) && (32'(nx) <= 32'(BOUND_DEPTH)) &&
                  (ny != '0) && (32'(ny) <= 32'(BOUND_DEPTH)) &&
                  (32'(cfg_prod) <= 32'(CELL_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) built <= 1'b0;
    else if (cmd.set_built) built <= 1'b1;
    else if (cmd.clr_built) built <= 1'b0;
  end

  // boundary memories, one read port per lane
  always_ff @(posedge clk) begin
    if (cmd.ld_x) bx_mem[IW'(entry_index)] <= key_x_lo;
    if (cmd.ld_y) by_mem[IW'(entry_index)] <= key_x_lo;
    brd[0] <= bx_mem[mid[0]];
    brd[1] <= bx_mem[mid[1]];
    brd[2] <= by_mem[mid[2]];
    brd[3] <= by_mem[mid[3]];
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mid[l] = IW'(((IW+1)'(lo[l]) + (IW+1)'(hi[l]) + (IW+1)'(1)) >> 1);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      if (cmd.srch_start) begin
        lo[l] <= '0;
        hi[l] <= (l < 2) ? IW'(nx - NW'(1)) : IW'(ny - NW'(1));
      end else if (cmd.srch_upd && lo[l] < hi[l]) begin
        if (brd[l] <= key[l]) lo[l] <= mid[l];
        else hi[l] <= mid[l] - IW'(1);
      end
    end
    if (cmd.srch_start) begin
      key[0] <= key_x_lo;
      key[1] <= key_x_hi;
      key[2] <= key_y_lo;
      key[3] <= key_y_hi;
    end
  end

  // cell addressing
  assign nyc     = CW'(ny);
  assign byl_c   = CW'(lo[2]);
  assign byh_c   = CW'(lo[3]);
  assign prod_lo = PW'(lo[0]) * PW'(ny);
  assign prod_hi = PW'(lo[1]) * PW'(ny);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      row_lo <= CW'(prod_lo);
      row_hi <= CW'(prod_hi);
    end
  end

  always_comb begin
    raddr0 = addr;
    raddr1 = addr - nyc;
    if (cmd.qa) begin
      raddr0 = row_hi + byh_c;
      raddr1 = row_lo - nyc + byh_c;
    end else if (cmd.qb) begin
      raddr0 = row_hi + byl_c - CW'(1);
      raddr1 = row_lo - nyc + byl_c - CW'(1);
    end else if (cmd.add_rd) begin
      raddr0 = row_lo + byl_c;
    end
  end

  assign rs_new = ((bj == '0) ? '0 : rowsum) + rd0;

  always_comb begin
    we = cmd.clr_wr || cmd.add_wr || cmd.bld_wr;
    waddr = addr;
    wdata = '0;
    if (cmd.add_wr) begin
      waddr = row_lo + byl_c;
      wdata = rd0 + COUNT_WIDTH'(1);
    end else if (cmd.bld_wr) begin
      wdata = rs_new + ((bi == '0) ? '0 : rd1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) cell_mem[waddr] <= wdata;
    rd0 <= cell_mem[raddr0];
    rd1 <= cell_mem[raddr1];
  end

  // sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.clr_start || cmd.bld_start) begin
      addr <= '0;
    end else if (cmd.clr_wr || cmd.bld_wr) begin
      addr <= addr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bld_start) begin
      bi <= '0;
      bj <= '0;
    end else if (cmd.bld_wr) begin
      rowsum <= rs_new;
      if (bj == ny - NW'(1)) begin
        bj <= '0;
        bi <= bi + NW'(1);
      end else begin
        bj <= bj + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.qb) begin
      pa <= rd0;
      pb <= rd1;
    end
  end

  // inclusion-exclusion over the four prefix reads
  always_comb begin
    est = pa - ((lo[0] == '0) ? '0 : pb) - ((lo[2] == '0) ? '0 : rd0)
        + ((lo[0] == '0 || lo[2] == '0) ? '0 : rd1);
    if (!(lo[1] >= lo[0] && lo[3] >= lo[2])) est = '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status   <= cmd.res_status;
      estimate <= cmd.res_query ? 32'(est) : 32'd0;
      bucket_x <= (cmd.res_add || cmd.res_query) ? 12'(lo[0]) : 12'd0;
      bucket_y <= (cmd.res_add || cmd.res_query) ? 12'(lo[2]) : 12'd0;
    end
  end

  always_comb begin
    stat.cfg_ok     = cfg_ok;
    stat.built      = built;
    stat.idx_bad    = (32'(entry_index) >= 32'(BOUND_DEPTH));
    stat.srch_done  = (lo[0] >= hi[0]) && (lo[1] >= hi[1]) &&
                      (lo[2] >= hi[2]) && (lo[3] >= hi[3]);
    stat.sweep_last = (addr == CW'(CELL_DEPTH - 1));
    stat.bld_last   = (bi == nx - NW'(1)) && (bj == ny - NW'(1));
  end

endmodule

>>> rtl/core/histogram_range_count_estimator.sv
// ----------------------------------------------------------------------------
// histogram_range_count_estimator
// 2D histogram range count estimator: boundary loads, point adds, in-place
// prefix build, clear and inclusion-exclusion range queries.
// ----------------------------------------------------------------------------
// Loads and rejected requests answer from idle. Add and query binary-search
//   the bounds (up to clog2(BOUND_DEPTH) steps) and multiply the row, then add
//   reads and writes one cell and query reads four prefix sums. Build reads and
//   writes the nx*ny cells; clear writes one cell a cycle. No request is taken
//   while busy. Reset: a clearing pass zeroes the cells; busy stays high.
module histogram_range_count_estimator #(
  parameter int BOUND_DEPTH = 4096,
  parameter int CELL_DEPTH  = 65536,
  parameter int KEY_WIDTH   = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type,
  input  logic [11:0]                 entry_index,
  input  logic signed [KEY_WIDTH-1:0] key_x_lo,
  input  logic signed [KEY_WIDTH-1:0] key_x_hi,
  input  logic signed [KEY_WIDTH-1:0] key_y_lo,
  input  logic signed [KEY_WIDTH-1:0] key_y_hi,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [31:0]                 estimate,
  output logic [11:0]                 bucket_x,
  output logic [11:0]                 bucket_y,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [12:0]                 cfg_data
);

  hrce_pkg::cmd_t  cmd;
  hrce_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  hrce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done)
  );

  hrce_dp #(
    .BOUND_DEPTH (BOUND_DEPTH),
    .CELL_DEPTH  (CELL_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry_index (entry_index),
    .key_x_lo    (key_x_lo),
    .key_x_hi    (key_x_hi),
    .key_y_lo    (key_y_lo),
    .key_y_hi    (key_y_hi),
    .status      (status),
    .estimate    (estimate),
    .bucket_x    (bucket_x),
    .bucket_y    (bucket_y)
  );

endmodule

>>> rtl/core/hrce_checker.sv
// ----------------------------------------------------------------------------
// hrce_checker
// Port-level checks of request and result beat ordering, error result fields and the reset clearing pass.
// ----------------------------------------------------------------------------
module hrce_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] estimate,
  input logic [11:0] bucket_x,
  input logic [11:0] bucket_y
);

  a_accept_then_work: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted beat produced neither work nor result");

  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result beat without a request");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != hrce_pkg::ST_OK) |-> (estimate == 32'd0 &&
                                             bucket_x == 12'd0 &&
                                             bucket_y == 12'd0))
    else $error("error result carries nonzero fields");

  a_reset_clears: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (busy && !done))
    else $error("reset did not start the clearing pass");

endmodule

bind histogram_range_count_estimator hrce_checker u_hrce_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .estimate (estimate),
  .bucket_x (bucket_x),
  .bucket_y (bucket_y)
);

>>> verif/histogram_range_count_estimator_tb.sv
// ----------------------------------------------------------------------------
// histogram_range_count_estimator_tb
// Self-checking bench for the 2D histogram range count estimator. Drives
// boundary loads, point adds, prefix builds, clears and range queries over
// several bucket shapes, and checks every result against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_range_count_estimator_tb;

  localparam int BOUNDS = 4096;
  localparam int CELLS  = 65536;
  localparam int IDLE_LIMIT = 1000000;

  typedef struct {
    logic [2:0]         req;
    logic [11:0]        idx;
    logic signed [31:0] xlo, xhi, ylo, yhi;
  } req_beat_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] est;
    logic [11:0] bx, by;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [2:0] req_type = '0;
  logic [11:0] entry_index = '0;
  logic signed [31:0] key_x_lo = '0, key_x_hi = '0, key_y_lo = '0, key_y_hi = '0;
  logic [1:0] status;
  logic [31:0] estimate;
  logic [11:0] bucket_x, bucket_y;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  histogram_range_count_estimator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .entry_index(entry_index),
    .key_x_lo(key_x_lo), .key_x_hi(key_x_hi), .key_y_lo(key_y_lo), .key_y_hi(key_y_hi),
    .done(done), .status(status), .estimate(estimate),
    .bucket_x(bucket_x), .bucket_y(bucket_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // histogram model state
  logic [31:0] ord_x [BOUNDS];
  logic [31:0] ord_y [BOUNDS];
  logic signed [31:0] raw_x [BOUNDS];
  logic signed [31:0] raw_y [BOUNDS];
  logic [31:0] hist [CELLS];
  logic        hist_built;
  logic [12:0] nbx, nby;

  answer_t pending_answers[$];
  int errs = 0, n_items = 0, n_answers = 0, n_counts = 0, idle_cycles = 0;
  int burst_left = 0;
  bit at_fall = 0;

  function automatic logic [31:0] key_ord(logic signed [31:0] k);
    return {~k[31], k[30:0]};
  endfunction

  function automatic logic [11:0] bucket_of(bit isx, int n, logic signed [31:0] k);
    int lo, hi, mid;
    logic [31:0] ko, b;
    lo = 0;
    hi = n - 1;
    ko = key_ord(k);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      b = isx ? ord_x[mid] : ord_y[mid];
      if (b <= ko) lo = mid;
      else hi = mid - 1;
    end
    return lo[11:0];
  endfunction

  function automatic logic [31:0] prefix_below(int x, int y);
    if (x == 0 || y == 0) return 32'd0;
    return hist[(x - 1) * nby + (y - 1)];
  endfunction

  function automatic answer_t predict_answer(req_beat_t r);
    answer_t a;
    int nx, ny, ux, uy, c;
    bit cfg_good;
    a = '{hrce_pkg::ST_OK, 32'd0, 12'd0, 12'd0};
    nx = nbx;
    ny = nby;
    cfg_good = nx >= 1 && nx <= BOUNDS && ny >= 1 && ny <= BOUNDS && nx * ny <= CELLS;
    case (r.req)
      hrce_pkg::REQ_LOAD_X: begin
        ord_x[r.idx] = key_ord(r.xlo);
        raw_x[r.idx] = r.xlo;
      end
      hrce_pkg::REQ_LOAD_Y: begin
        ord_y[r.idx] = key_ord(r.xlo);
        raw_y[r.idx] = r.xlo;
      end
      hrce_pkg::REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) hist[i] = '0;
        hist_built = 1'b0;
      end
      hrce_pkg::REQ_ADD, hrce_pkg::REQ_BUILD, hrce_pkg::REQ_QUERY: begin
        if (!cfg_good) a.st = hrce_pkg::ST_CFG;
        else if ((r.req == hrce_pkg::REQ_QUERY) != hist_built) a.st = hrce_pkg::ST_PHASE;
        else if (r.req == hrce_pkg::REQ_ADD) begin
          a.bx = bucket_of(1, nx, r.xlo);
          a.by = bucket_of(0, ny, r.ylo);
          c = a.bx * ny + a.by;
          hist[c] = hist[c] + 32'd1;
        end else if (r.req == hrce_pkg::REQ_BUILD) begin
          for (int i = 0; i < nx; i++)
            for (int j = 0; j < ny; j++) begin
              logic [31:0] v;
              v = hist[i * ny + j];
              if (i > 0) v += hist[(i - 1) * ny + j];
              if (j > 0) v += hist[i * ny + j - 1];
              if (i > 0 && j > 0) v -= hist[(i - 1) * ny + j - 1];
              hist[i * ny + j] = v;
            end
          hist_built = 1'b1;
        end else begin
          a.bx = bucket_of(1, nx, r.xlo);
          ux = bucket_of(1, nx, r.xhi) + 1;
          a.by = bucket_of(0, ny, r.ylo);
          uy = bucket_of(0, ny, r.yhi) + 1;
          if (ux > a.bx && uy > a.by)
            a.est = prefix_below(ux, uy) - prefix_below(a.bx, uy)
                  - prefix_below(ux, a.by) + prefix_below(a.bx, a.by);
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic send_req(req_beat_t r);
    int gap;
    if (!at_fall) @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_type = r.req;
    entry_index = r.idx;
    key_x_lo = r.xlo;
    key_x_hi = r.xhi;
    key_y_lo = r.ylo;
    key_y_hi = r.yhi;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_answers.insert(pending_answers.size(), predict_answer(r));
    n_items++;
    @(negedge clk);
    start = 1'b0;
    at_fall = 1;
  endtask

  task automatic send_op(logic [2:0] req, logic [11:0] idx = '0,
                         logic signed [31:0] xlo = '0, logic signed [31:0] xhi = '0,
                         logic signed [31:0] ylo = '0, logic signed [31:0] yhi = '0);
    req_beat_t r;
    r = '{req, idx, xlo, xhi, ylo, yhi};
    send_req(r);
  endtask

  task automatic wait_idle();
    while (pending_answers.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    at_fall = 1;
  endtask

  task automatic write_count(logic which, logic [12:0] val);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = which;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (which == hrce_pkg::CFG_COUNT_X) nbx = val;
    else nby = val;
    @(negedge clk);
    cfg_valid = 1'b0;
    at_fall = 1;
  endtask

  task automatic load_bounds(bit isx, int n, bit ordered);
    logic signed [63:0] k, stepmax;
    k = -64'sd2147483648 + 64'($urandom_range(0, 3));
    stepmax = 64'sd4294967295 / n;
    for (int i = 1; i < n; i++) begin
      if (ordered) begin
        k = k + 64'($urandom_range(0,
              32'(stepmax > 64'sd1000000000 ? 64'sd1000000000 : stepmax)));
        if (i == n - 1 && $urandom_range(0, 1)) k = 64'sd2147483647;
      end else k = 64'($signed($urandom));
      send_op(isx ? hrce_pkg::REQ_LOAD_X : hrce_pkg::REQ_LOAD_Y, i[11:0], k[31:0]);
    end
  endtask

  function automatic logic signed [31:0] pick_key(bit isx);
    int n, s;
    logic signed [31:0] b;
    n = isx ? nbx : nby;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2: begin
        if (n < 2) return $urandom;
        s = $urandom_range(1, n - 1);
        b = isx ? raw_x[s] : raw_y[s];
        return b + $signed($urandom_range(0, 2)) - 1;
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic noise_beat();
    case ($urandom_range(0, 3))
      0: send_op(3'(6 + $urandom_range(0, 1)), 12'($urandom), $urandom, $urandom,
                 $urandom, $urandom);
      1: send_op(hrce_pkg::REQ_QUERY, 12'd0, pick_key(1), pick_key(1), pick_key(0),
                 pick_key(0));
      2: send_op(hrce_pkg::REQ_ADD, 12'($urandom), pick_key(1), $urandom, pick_key(0),
                 $urandom);
      default: send_op(hrce_pkg::REQ_BUILD);
    endcase
  endtask

  task automatic run_session(int nx, int ny, bit ordered, int n_add, int n_query);
    logic signed [31:0] a, b, c, d;
    write_count(hrce_pkg::CFG_COUNT_X, 13'(nx));
    write_count(hrce_pkg::CFG_COUNT_Y, 13'(ny));
    load_bounds(1, nx, ordered);
    load_bounds(0, ny, ordered);
    if (hist_built) send_op(hrce_pkg::REQ_CLEAR);
    for (int i = 0; i < n_add; i++) begin
      if ($urandom_range(0, 9) == 0) noise_beat();
      else send_op(hrce_pkg::REQ_ADD, 12'($urandom), pick_key(1), $urandom, pick_key(0),
                   $urandom);
    end
    send_op(hrce_pkg::REQ_BUILD);
    for (int i = 0; i < n_query; i++) begin
      if ($urandom_range(0, 9) == 0) noise_beat();
      else begin
        a = pick_key(1); b = pick_key(1); c = pick_key(0); d = pick_key(0);
        if ($urandom_range(0, 5) != 0 && a > b) begin a = b; b = pick_key(1); end
        if ($urandom_range(0, 5) != 0 && c > d) begin c = d; d = pick_key(0); end
        send_op(hrce_pkg::REQ_QUERY, 12'($urandom), a, b, c, d);
      end
    end
  endtask

  task automatic test_directed();
    send_op(hrce_pkg::REQ_QUERY, 12'd0, 0, 0, 0, 0);
    send_op(hrce_pkg::REQ_ADD, 12'hfff, 32'sh80000000, 0, 32'sh7fffffff, 0);
    send_op(hrce_pkg::REQ_ADD, 12'd0, 32'sh7fffffff, 0, 32'sh80000000, 0);
    send_op(hrce_pkg::REQ_LOAD_X, 12'hfff, 32'sh7fffffff);
    send_op(hrce_pkg::REQ_LOAD_Y, 12'd0, 32'sh80000000);
    send_op(hrce_pkg::REQ_BUILD);
    send_op(hrce_pkg::REQ_ADD, 12'd0, 5, 0, 5, 0);
    send_op(hrce_pkg::REQ_BUILD);
    send_op(hrce_pkg::REQ_QUERY, 12'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
            32'sh7fffffff);
    send_op(hrce_pkg::REQ_QUERY, 12'd0, 32'sh7fffffff, 32'sh80000000, 0, 0);
    send_op(3'd6, 12'hfff, -1, -1, -1, -1);
    send_op(3'd7, 12'h555, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
    send_op(hrce_pkg::REQ_CLEAR);
    send_op(hrce_pkg::REQ_QUERY);
    write_count(hrce_pkg::CFG_COUNT_X, 13'd0);
    send_op(hrce_pkg::REQ_ADD);
    send_op(hrce_pkg::REQ_QUERY);
    write_count(hrce_pkg::CFG_COUNT_X, 13'h1fff);
    send_op(hrce_pkg::REQ_BUILD);
    write_count(hrce_pkg::CFG_COUNT_X, 13'd4096);
    write_count(hrce_pkg::CFG_COUNT_Y, 13'd4096);
    send_op(hrce_pkg::REQ_ADD);
    write_count(hrce_pkg::CFG_COUNT_Y, 13'd4097);
    send_op(hrce_pkg::REQ_QUERY);
  endtask

  task automatic test_extreme_shapes();
    run_session(256, 1, 1, 30, 30);
    run_session(1, 256, 1, 30, 30);
    run_session(32, 32, 1, 40, 40);
  endtask

  task automatic test_random_traffic();
    run_session($urandom_range(2, 16), $urandom_range(2, 16), 1, 100, 80);
    run_session($urandom_range(1, 40), $urandom_range(1, 8), 0, 60, 60);
    run_session($urandom_range(2, 8), $urandom_range(2, 64), 1, 80, 60);
    run_session($urandom_range(2, 6), $urandom_range(2, 6), 1, 60, 50);
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      n_answers++;
      if (pending_answers.size() == 0) begin
        errs++;
        $display("%0t: unexpected result status=%0d estimate=%0d", $time, status, estimate);
      end else begin
        e = pending_answers.pop_front();
        if (e.st == hrce_pkg::ST_OK && e.est != 0) n_counts++;
        if (status !== e.st || estimate !== e.est || bucket_x !== e.bx || bucket_y !== e.by) begin
          errs++;
          $display("%0t: mismatch exp st=%0d est=%0d bx=%0d by=%0d got st=%0d est=%0d bx=%0d by=%0d",
                   $time, e.st, e.est, e.bx, e.by, status, estimate, bucket_x, bucket_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending_answers.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < BOUNDS; i++) begin
      ord_x[i] = '0; ord_y[i] = '0; raw_x[i] = '0; raw_y[i] = '0;
    end
    for (int i = 0; i < CELLS; i++) hist[i] = '0;
    hist_built = 1'b0;
    nbx = 13'd1;
    nby = 13'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    at_fall = 1;
    test_directed();
    test_extreme_shapes();
    test_random_traffic();
    wait_idle();
    repeat (50) @(posedge clk);
    if (pending_answers.size() != 0) begin
      errs++;
      $display("%0t: %0d results never arrived", $time, pending_answers.size());
    end
    $display("Ran %0d requests, checked %0d results, %0d nonzero range counts.",
             n_items, n_answers, n_counts);
    $display("Shapes covered: degenerate, 256x1, 1x256, 32x32 and random grids.");
    if (errs == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
